[sv/pie_pkg.sv]
// Types and constants shared by the palette index expander modules.
package pie_pkg;

  // Byte lanes of one palette entry and of the banked palette store
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;
  localparam int ADDR_W      = 10;

  // Classified queue between front and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Result buffer in the back end
  localparam int OUT_DEPTH   = 4;
  localparam int OPTR_W      = 2;

  // Configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam logic REG_INDEX_MODE  = 1'b0;
  localparam logic REG_ENTRY_BYTES = 1'b1;

  // Item and mode codes
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_EXPAND  = 1'b1;
  localparam logic MODE_NIBBLE = 1'b0;
  localparam logic MODE_BYTE   = 1'b1;

  localparam logic [2:0] ENTRY_MIN   = 3'd2;
  localparam logic [2:0] ENTRY_MAX   = 3'd4;
  localparam logic [2:0] ENTRY_RESET = 3'd2;

  localparam logic [7:0] NIBBLE_MASK  = 8'd15;
  localparam int         NIBBLE_SHIFT = 4;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] palette_address;
    logic              level_end_in;
  } req_t;

  typedef struct packed {
    logic [31:0] entry_value;
    logic        run_last;
    logic        level_end_out;
  } pix_t;

  typedef struct packed {
    logic              is_load;
    logic              two_px;
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] palette_address;
    logic              level_end;
  } cls_t;

endpackage

[sv/pie_front.sv]
// Front end: configuration registers and classification of incoming words.
module pie_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pie_pkg::PADDR_W-1:0] paddr,
  input  logic [pie_pkg::PDATA_W-1:0] pwdata,
  output logic [pie_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  pie_pkg::req_t               req,
  input  logic                        queue_full,
  output logic                        push,
  output pie_pkg::cls_t               push_item,
  output logic [2:0]                  entry_size
);

  logic       index_mode;
  logic [2:0] entry_bytes;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_mode  <= pie_pkg::MODE_BYTE;
      entry_bytes <= pie_pkg::ENTRY_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        pie_pkg::REG_INDEX_MODE:  index_mode  <= pwdata[0];
        pie_pkg::REG_ENTRY_BYTES: entry_bytes <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pie_pkg::REG_INDEX_MODE:  prdata = {{(pie_pkg::PDATA_W-1){1'b0}}, index_mode};
      pie_pkg::REG_ENTRY_BYTES: prdata = {{(pie_pkg::PDATA_W-3){1'b0}}, entry_bytes};
      default:                  prdata = '0;
    endcase
  end

  // Clamp entry size into the legal range
  always_comb begin
    if (entry_bytes < pie_pkg::ENTRY_MIN) begin
      entry_size = pie_pkg::ENTRY_MIN;
    end else if (entry_bytes > pie_pkg::ENTRY_MAX) begin
      entry_size = pie_pkg::ENTRY_MAX;
    end else begin
      entry_size = entry_bytes;
    end
  end

  assign req_ready = !queue_full;
  assign push      = req_valid && !queue_full;

  always_comb begin
    push_item.is_load         = (req.req_type == pie_pkg::REQ_LOAD);
    push_item.two_px          = (req.req_type == pie_pkg::REQ_EXPAND) &&
                                (index_mode == pie_pkg::MODE_NIBBLE);
    push_item.data_byte       = req.data_byte;
    push_item.palette_address = req.palette_address;
    push_item.level_end       = req.level_end_in;
  end

endmodule

[sv/pie_queue.sv]
// Short queue of classified words between front and back end.
module pie_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pie_pkg::cls_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pie_pkg::cls_t head
);

  pie_pkg::cls_t                mem [pie_pkg::QUEUE_DEPTH];
  logic [pie_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pie_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pie_pkg::QPTR_W:0]     count;

  assign full       = (count == (pie_pkg::QPTR_W+1)'(pie_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

[sv/pie_back.sv]
// Back end: banked palette store, pixel sequencing, entry assembly, result buffer.
module pie_back #(
  parameter int PALETTE_BYTES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  pie_pkg::cls_t head,
  output logic          pop,
  input  logic [2:0]    entry_size,
  output logic          pix_valid,
  input  logic          pix_ready,
  output pie_pkg::pix_t pix
);

  localparam int BANK_DEPTH = (PALETTE_BYTES + pie_pkg::LANES - 1) / pie_pkg::LANES;
  localparam int ROW_W      = $clog2(BANK_DEPTH);
  localparam logic [pie_pkg::ADDR_W:0] PAL_LIMIT = (pie_pkg::ADDR_W+1)'(PALETTE_BYTES);

  logic [7:0] mem [pie_pkg::LANES][BANK_DEPTH];
  logic [7:0] rd_q [pie_pkg::LANES];

  logic phase, phase_next;
  logic do_write, do_read, can_issue, wr_in_range;
  logic [ROW_W-1:0] wr_row;
  logic [7:0] idx;
  logic [pie_pkg::ADDR_W-1:0] base;
  logic [pie_pkg::ADDR_W-1:0] lane_addr [pie_pkg::LANES];
  logic [ROW_W-1:0] rd_row [pie_pkg::LANES];
  logic [pie_pkg::LANES-1:0] byte_mask;
  logic run_last;

  logic                       meta_valid;
  logic [pie_pkg::LANE_W-1:0] meta_rot;
  logic [pie_pkg::LANES-1:0]  meta_mask;
  logic                       meta_run_last;
  logic                       meta_lend;

  pie_pkg::pix_t              obuf [pie_pkg::OUT_DEPTH];
  pie_pkg::pix_t              assembled;
  logic [pie_pkg::OPTR_W-1:0] owr_ptr, ord_ptr;
  logic [pie_pkg::OPTR_W:0]   ocount;
  logic                       opop;

  // Issue only when the result buffer has room for everything in flight
  assign can_issue = (ocount + (pie_pkg::OPTR_W+1)'(meta_valid)) <
                     (pie_pkg::OPTR_W+1)'(pie_pkg::OUT_DEPTH);

  always_comb begin
    do_write    = head_valid && head.is_load;
    do_read     = head_valid && !head.is_load && can_issue;
    run_last    = !head.two_px || phase;
    pop         = do_write || (do_read && run_last);
    phase_next  = phase;
    if (do_read && head.two_px) begin
      phase_next = !phase;
    end
    wr_in_range = ({1'b0, head.palette_address} < PAL_LIMIT);
    wr_row      = head.palette_address[ROW_W+1:2];
    if (!head.two_px) begin
      idx = head.data_byte;
    end else if (phase) begin
      idx = head.data_byte & pie_pkg::NIBBLE_MASK;
    end else begin
      idx = (head.data_byte >> pie_pkg::NIBBLE_SHIFT) & pie_pkg::NIBBLE_MASK;
    end
    base = {2'b00, idx} * {7'd0, entry_size};
  end

  // Per-lane address and byte validity; the lane offset wraps modulo the lane count
  always_comb begin
    for (int b = 0; b < pie_pkg::LANES; b++) begin
      lane_addr[b] = base + {{(pie_pkg::ADDR_W-pie_pkg::LANE_W){1'b0}},
                             pie_pkg::LANE_W'(pie_pkg::LANE_W'(b) - base[1:0])};
      rd_row[b]    = lane_addr[b][ROW_W+1:2];
      byte_mask[b] = (3'(b) < entry_size) &&
                     ({1'b0, base + pie_pkg::ADDR_W'(b)} < PAL_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < pie_pkg::LANES; b++) begin
      if (do_write && wr_in_range && (head.palette_address[1:0] == 2'(b))) begin
        mem[b][wr_row] <= head.data_byte;
      end
      if (do_read) begin
        rd_q[b] <= mem[b][rd_row[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_valid <= 1'b0;
    end else begin
      meta_valid <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      meta_rot      <= base[1:0];
      meta_mask     <= byte_mask;
      meta_run_last <= run_last;
      meta_lend     <= run_last && head.level_end;
    end
  end

  // Rotate bank bytes back into entry order
  always_comb begin
    assembled.entry_value   = '0;
    assembled.run_last      = meta_run_last;
    assembled.level_end_out = meta_lend;
    for (int k = 0; k < pie_pkg::LANES; k++) begin
      if (meta_mask[k]) begin
        assembled.entry_value[8*k +: 8] = rd_q[meta_rot + 2'(k)];
      end
    end
  end

  assign pix_valid = (ocount != '0);
  assign pix       = obuf[ord_ptr];
  assign opop      = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (meta_valid) begin
        owr_ptr <= owr_ptr + 1'b1;
      end
      if (opop) begin
        ord_ptr <= ord_ptr + 1'b1;
      end
      case ({meta_valid, opop})
        2'b10:   ocount <= ocount + 1'b1;
        2'b01:   ocount <= ocount - 1'b1;
        default: ocount <= ocount;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (meta_valid) begin
      obuf[owr_ptr] <= assembled;
    end
  end

endmodule

[sv/palette_index_expander_top.sv]
// Top level of the palette index expander: front end, queue and back end.
//
// The block expands paletted texture data. Load words (req_type 0) write one
// palette byte at palette_address; addresses at or beyond PALETTE_BYTES are
// dropped. Expand words (req_type 1) carry one packed index byte: in 4-bit
// mode (index_mode 0) it yields two pixels, high nibble first, in 8-bit mode
// one pixel. Each pixel is the entry_bytes-byte palette entry at
// index * entry_bytes, byte 0 in bits 7:0, upper bytes zero; bytes beyond the
// store read as zero. entry_bytes is clamped to 2..4. run_last marks the
// last pixel of an index byte and level_end_out repeats level_end_in there.
// Rate: the back end reads one palette entry per cycle from four byte-wide
// banks while the result buffer has room, so it sustains one pixel per cycle:
// one word per cycle in 8-bit mode and for loads, one word per two pixels in
// 4-bit mode. A word's first pixel passes the queue, the bank read register
// and the result buffer before it is offered. A four-word queue separates
// acceptance from the back end and a four-entry result buffer keeps the back
// end running while the output stalls.
// The palette store is not cleared at reset; read only entries already
// loaded. Write configuration only while the block is idle.
module palette_index_expander_top #(
  parameter int PALETTE_BYTES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pie_pkg::PADDR_W-1:0] paddr,
  input  logic [pie_pkg::PDATA_W-1:0] pwdata,
  output logic [pie_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  pie_pkg::req_t               req,
  output logic                        pix_valid,
  input  logic                        pix_ready,
  output pie_pkg::pix_t               pix
);

  // Front to queue
  logic          push;
  logic          queue_full;
  pie_pkg::cls_t push_item;

  // Queue to back
  logic          head_valid;
  logic          pop;
  pie_pkg::cls_t head;

  // Clamped entry size; the user must hold it steady while busy, the block does not enforce it
  logic [2:0]    entry_size;

  // Accept and classify words; hold configuration
  pie_front u_front (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item),
    .entry_size (entry_size)
  );

  // Decouple acceptance from palette access
  pie_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Store palette bytes, fetch entries, buffer results
  pie_back #(
    .PALETTE_BYTES (PALETTE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .entry_size (entry_size),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix)
  );

endmodule

[sim/tb_palette_index_expander_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the palette index expander: random load and expand words, APB setup.
module tb_palette_index_expander_top;

  localparam int PALETTE_BYTES = 1024;
  // Queue, bank read and result buffer plus a four-word queue still full of loads
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_WORDS   = 190;
  localparam int PHASES        = 8;

  localparam logic [pie_pkg::PADDR_W-1:0] ADDR_INDEX_MODE  = {pie_pkg::REG_INDEX_MODE, 2'b00};
  localparam logic [pie_pkg::PADDR_W-1:0] ADDR_ENTRY_BYTES = {pie_pkg::REG_ENTRY_BYTES, 2'b00};

  // Settings per random phase, phase 0 in the low bits. Entry sizes 0 and 7 exercise
  // the clamp; the last phase returns to the reset values.
  localparam logic [PHASES-1:0]   PHASE_MODE  = 8'b1010_1010;
  localparam logic [PHASES*3-1:0] PHASE_ENTRY = {3'd2, 3'd7, 3'd0, 3'd4,
                                                 3'd3, 3'd3, 3'd4, 3'd2};

  logic                        clk     = 1'b0;
  logic                        rst     = 1'b1;
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [pie_pkg::PADDR_W-1:0] paddr   = '0;
  logic [pie_pkg::PDATA_W-1:0] pwdata  = '0;
  logic [pie_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  pie_pkg::req_t               req       = '0;
  logic                        pix_valid;
  logic                        pix_ready = 1'b0;
  pie_pkg::pix_t               pix;

  // Sender side
  pie_pkg::req_t pending_words[$];
  int   req_gap = 0;
  logic req_hs  = 1'b0;
  bit   idle_on = 1'b1;

  // Receiver side
  bit   long_hold_go   = 1'b0;
  bit   long_hold_used = 1'b0;
  int   hold_left      = 0;

  // Expected behaviour: own copy of the palette and of both registers
  logic [7:0]    palette_copy [PALETTE_BYTES];
  logic          mode_now  = pie_pkg::MODE_BYTE;
  logic [2:0]    entry_now = pie_pkg::ENTRY_RESET;
  pie_pkg::pix_t pixels_due[$];
  int            mismatches = 0;
  int            cycles     = 0;

  // Bytes already loaded; an expand word only ever names fully loaded entries
  bit loaded [PALETTE_BYTES];
  int issued = 0;

  always #2 clk = ~clk;

  palette_index_expander_top #(
    .PALETTE_BYTES(PALETTE_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix)
  );

  // Clamp the entry size register to the sizes the block supports
  function automatic int entry_size(logic [2:0] eb);
    if (eb < pie_pkg::ENTRY_MIN) return int'(pie_pkg::ENTRY_MIN);
    if (eb > pie_pkg::ENTRY_MAX) return int'(pie_pkg::ENTRY_MAX);
    return int'(eb);
  endfunction

  // Assemble one palette entry, byte 0 in the low bits; bytes past the store read zero
  function automatic logic [31:0] entry_at(int idx);
    int          size;
    int          addr;
    logic [31:0] value;
    size  = entry_size(entry_now);
    value = '0;
    for (int k = 0; k < size; k++) begin
      addr = idx * size + k;
      if (addr < PALETTE_BYTES) value |= 32'(palette_copy[addr]) << (8 * k);
    end
    return value;
  endfunction

  // Update the palette copy for a load, or queue the pixels an index byte yields
  function automatic void expand_word(pie_pkg::req_t w);
    pie_pkg::pix_t p;
    if (w.req_type == pie_pkg::REQ_LOAD) begin
      if (w.palette_address < PALETTE_BYTES) palette_copy[w.palette_address] = w.data_byte;
    end else if (mode_now == pie_pkg::MODE_NIBBLE) begin
      // High nibble first; only the second pixel carries the end flags
      p.entry_value   = entry_at(int'((w.data_byte >> pie_pkg::NIBBLE_SHIFT) &
                                      pie_pkg::NIBBLE_MASK));
      p.run_last      = 1'b0;
      p.level_end_out = 1'b0;
      pixels_due.push_back(p);
      p.entry_value   = entry_at(int'(w.data_byte & pie_pkg::NIBBLE_MASK));
      p.run_last      = 1'b1;
      p.level_end_out = w.level_end_in;
      pixels_due.push_back(p);
    end else begin
      p.entry_value   = entry_at(int'(w.data_byte));
      p.run_last      = 1'b1;
      p.level_end_out = w.level_end_in;
      pixels_due.push_back(p);
    end
  endfunction

  function automatic void push_load(logic [pie_pkg::ADDR_W-1:0] a, logic [7:0] d);
    pie_pkg::req_t w;
    w.req_type        = pie_pkg::REQ_LOAD;
    w.data_byte       = d;
    w.palette_address = a;
    w.level_end_in    = 1'($urandom_range(0, 3) == 0);
    pending_words.push_back(w);
    loaded[a] = 1'b1;
    issued++;
  endfunction

  function automatic void load_entry(int idx);
    int size;
    size = entry_size(entry_now);
    for (int k = 0; k < size; k++) begin
      push_load(pie_pkg::ADDR_W'(idx * size + k), 8'($urandom));
    end
  endfunction

  function automatic bit entry_loaded(int idx);
    int size;
    int addr;
    size = entry_size(entry_now);
    for (int k = 0; k < size; k++) begin
      addr = idx * size + k;
      if (addr < PALETTE_BYTES && !loaded[addr]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Well-formed sequence: load any entry the index byte needs, then expand it
  function automatic void push_expand(logic [7:0] d, logic lend);
    pie_pkg::req_t w;
    int            hi;
    int            lo;
    hi = int'((d >> pie_pkg::NIBBLE_SHIFT) & pie_pkg::NIBBLE_MASK);
    lo = int'(d & pie_pkg::NIBBLE_MASK);
    if (mode_now == pie_pkg::MODE_NIBBLE) begin
      if (!entry_loaded(hi)) load_entry(hi);
      if (!entry_loaded(lo)) load_entry(lo);
    end else if (!entry_loaded(int'(d))) begin
      load_entry(int'(d));
    end
    w.req_type        = pie_pkg::REQ_EXPAND;
    w.data_byte       = d;
    w.palette_address = pie_pkg::ADDR_W'($urandom);
    w.level_end_in    = lend;
    pending_words.push_back(w);
    issued++;
  endfunction

  // Mix of stray byte loads, whole entry reloads and expands with random content
  function automatic void fill_random(int count);
    int start;
    int r;
    int span;
    start = issued;
    span  = (mode_now == pie_pkg::MODE_NIBBLE) ? 16 : 256;
    while (issued - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        push_load(pie_pkg::ADDR_W'($urandom_range(0, PALETTE_BYTES - 1)), 8'($urandom));
      end else if (r < 30) begin
        load_entry($urandom_range(0, span - 1));
      end else begin
        push_expand(8'($urandom), 1'($urandom_range(0, 3) == 0));
      end
    end
  endfunction

  // APB write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [pie_pkg::PADDR_W-1:0] a,
                           input logic [pie_pkg::PDATA_W-1:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (a == ADDR_INDEX_MODE) mode_now = d[0];
    else if (a == ADDR_ENTRY_BYTES) entry_now = d[2:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every word is in and every pixel out, then let trailing loads drain
  task automatic wait_idle();
    while (pending_words.size() != 0 || req_valid || pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: present the next word at the falling edge once the last one is taken;
  // hold valid and payload steady until accepted, and insert random idle bursts
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_hs) begin
      if (req_gap > 0) begin
        req_valid <= 1'b0;
        req_gap   <= req_gap - 1;
      end else if (pending_words.size() > 0) begin
        req       <= pending_words.pop_front();
        req_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) req_gap <= $urandom_range(1, 8);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold so that the
  // queue and result buffer fill and the block stops taking words
  always @(negedge clk) begin
    if (rst) begin
      pix_ready <= 1'b0;
    end else if (long_hold_go && !long_hold_used) begin
      long_hold_used <= 1'b1;
      hold_left      <= LONG_HOLD;
      pix_ready      <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pix_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 7);
      pix_ready <= 1'b0;
    end else begin
      pix_ready <= 1'b1;
    end
  end

  // Monitor: sample both handshakes at the rising edge, check pixels in order,
  // predict from each accepted word, and guard the run with a cycle limit
  always @(posedge clk) begin
    pie_pkg::pix_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("palette_index_expander_top regression: fail");
      $finish;
    end else begin
      req_hs <= req_valid && req_ready;
      if (!rst && pix_valid && pix_ready) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel: entry_value %08h", pix.entry_value);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          if (pix.entry_value !== want.entry_value) begin
            $error("entry_value: expected %08h, got %08h", want.entry_value, pix.entry_value);
            mismatches++;
          end
          if (pix.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, pix.run_last);
            mismatches++;
          end
          if (pix.level_end_out !== want.level_end_out) begin
            $error("level_end_out: expected %0b, got %0b", want.level_end_out,
                   pix.level_end_out);
            mismatches++;
          end
        end
      end
      if (!rst && req_valid && req_ready) expand_word(req);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, 8-bit indices and 2-byte entries: lowest and highest
    // entries with all-zero and all-one bytes, the top store address, and loads
    // marked at random as level end (which must yield nothing)
    push_load(10'd0, 8'h00);
    push_load(10'd1, 8'hFF);
    push_load(10'd510, 8'hFF);
    push_load(10'd511, 8'h00);
    push_load(10'd1023, 8'hA5);
    push_expand(8'h00, 1'b0);
    push_expand(8'hFF, 1'b1);

    // 4-bit indices with 4-byte entries: both nibble extremes, each order
    wait_idle();
    reg_write(ADDR_INDEX_MODE, pie_pkg::PDATA_W'(pie_pkg::MODE_NIBBLE));
    reg_write(ADDR_ENTRY_BYTES, pie_pkg::PDATA_W'(pie_pkg::ENTRY_MAX));
    push_load(10'd0, 8'hFF);
    push_load(10'd1, 8'h00);
    push_load(10'd2, 8'hFF);
    push_load(10'd3, 8'h00);
    push_load(10'd60, 8'h01);
    push_load(10'd61, 8'h80);
    push_load(10'd62, 8'h7F);
    push_load(10'd63, 8'hFE);
    push_expand(8'h0F, 1'b0);
    push_expand(8'hF0, 1'b1);
    push_expand(8'h00, 1'b1);

    // Random phases, each under its own settings; drop idling in the last one
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES - 1) idle_on = 1'b0;
      reg_write(ADDR_INDEX_MODE, pie_pkg::PDATA_W'(PHASE_MODE[ph]));
      reg_write(ADDR_ENTRY_BYTES, pie_pkg::PDATA_W'(PHASE_ENTRY[ph*3 +: 3]));
      fill_random(PHASE_WORDS);
      if (ph == 1) long_hold_go = 1'b1;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("palette_index_expander_top regression: pass");
    end else begin
      $display("palette_index_expander_top regression: fail");
    end
    $finish;
  end

endmodule
